FILE: rtl/frl_pkg.sv
`timescale 1ns / 1ps

package frl_pkg;

    // Item field widths
    localparam int KIND_W  = 2;
    localparam int FRAME_W = 4;
    localparam int STAMP_W = 32;

    // Default number of frames
    localparam int FRAME_COUNT_DEF = 16;

    // Item kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_USE  = 2'd0,
        KIND_FIFO = 2'd1,
        KIND_LRU  = 2'd2,
        KIND_OCC  = 2'd3
    } kind_t;

    // Control sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_USE_SCAN,
        ST_USE_UPD,
        ST_FIFO_RD,
        ST_FIFO_WAIT,
        ST_LRU_SCAN,
        ST_EMIT
    } state_t;

endpackage

FILE: rtl/frl_if.sv
`timescale 1ns / 1ps

// Input item channel
interface frl_in_if;
    logic                        valid;
    logic                        ready;
    logic [frl_pkg::KIND_W-1:0]  kind;
    logic [frl_pkg::FRAME_W-1:0] frame;
    logic                        occupied_value;

    modport source (output valid, kind, frame, occupied_value, input ready);
    modport sink   (input valid, kind, frame, occupied_value, output ready);
endinterface

// Result item channel
interface frl_out_if;
    logic                        valid;
    logic                        ready;
    logic                        victim_valid;
    logic [frl_pkg::FRAME_W-1:0] victim_frame;

    modport source (output valid, victim_valid, victim_frame, input ready);
    modport sink   (input valid, victim_valid, victim_frame, output ready);
endinterface

FILE: rtl/frl_ring.sv
`timescale 1ns / 1ps

// FIFO ring storage: one write port, one registered read port
module frl_ring #(
    parameter int DEPTH  = frl_pkg::FRAME_COUNT_DEF,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic                        clk,
    input  logic                        wr_en,
    input  logic [ADDR_W-1:0]           wr_addr,
    input  logic [frl_pkg::FRAME_W-1:0] wr_data,
    input  logic [ADDR_W-1:0]           rd_addr,
    output logic [frl_pkg::FRAME_W-1:0] rd_data
);

    logic [frl_pkg::FRAME_W-1:0] mem [DEPTH];
    logic [frl_pkg::FRAME_W-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port, registered
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/frl_stamp.sv
`timescale 1ns / 1ps

// Use stamp storage; entries never written read as zero
module frl_stamp #(
    parameter int DEPTH  = frl_pkg::FRAME_COUNT_DEF,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        wr_en,
    input  logic [ADDR_W-1:0]           wr_addr,
    input  logic [frl_pkg::STAMP_W-1:0] wr_data,
    input  logic [ADDR_W-1:0]           rd_addr,
    output logic [frl_pkg::STAMP_W-1:0] rd_data
);

    logic [frl_pkg::STAMP_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0]            valid_reg;
    logic [frl_pkg::STAMP_W-1:0] rd_data_reg;
    logic                        rd_vld_reg;

    // Storage array
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // Per-entry written flags and read flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            rd_vld_reg <= valid_reg[rd_addr];
        end
    end

    assign rd_data = rd_vld_reg ? rd_data_reg : '0;

endmodule

FILE: rtl/frame_replacement_fifo_lru_core.sv
`timescale 1ns / 1ps

// Channel    Dir  Fields                          Handshake
// item_in    in   kind, frame, occupied_value     valid/ready
// result_out out  victim_valid, victim_frame      valid/ready
//
// Steps per item, from the accept. Occupancy item: applied on accept. FIFO select:
// emit when empty, else ring read, data, emit. Use item: presence scan of one
// ring read a cycle over the queued entries (none with an empty ring), then
// the read pipe drains and one update follows; a hit ends the scan.
// LRU select: one stamp memory read a cycle over every frame, then emit.
// Reset clears all control state and the stamp written flags at once.
// A result waits in the output register; a new item is taken meanwhile, and
// a select stalls in emit while the previous result is still held.
module frame_replacement_fifo_lru_core #(
    parameter int FRAME_COUNT = frl_pkg::FRAME_COUNT_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    frl_in_if.sink    item_in,
    frl_out_if.source result_out
);

    localparam int IDX_W = $clog2(FRAME_COUNT);
    localparam int CNT_W = $clog2(FRAME_COUNT + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(FRAME_COUNT);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(FRAME_COUNT - 1);

    frl_pkg::state_t state_reg, state_next;

    logic [frl_pkg::FRAME_W-1:0] frame_reg, frame_next;
    logic [IDX_W-1:0]            head_reg, head_next;
    logic [IDX_W-1:0]            tail_reg, tail_next;
    logic [CNT_W-1:0]            count_reg, count_next;
    logic [frl_pkg::STAMP_W-1:0] clock_reg, clock_next;
    logic [FRAME_COUNT-1:0]      occ_reg, occ_next;
    logic [CNT_W-1:0]            idx_reg, idx_next;
    logic [IDX_W-1:0]            pos_reg, pos_next;
    logic                        pend_reg, pend_next;
    logic                        pend_occ_reg, pend_occ_next;
    logic [IDX_W-1:0]            pend_idx_reg, pend_idx_next;
    logic                        hit_reg, hit_next;
    logic                        found_reg, found_next;
    logic [frl_pkg::STAMP_W-1:0] best_reg, best_next;
    logic [IDX_W-1:0]            best_idx_reg, best_idx_next;
    logic                        res_vv_reg, res_vv_next;
    logic [frl_pkg::FRAME_W-1:0] res_frame_reg, res_frame_next;
    logic                        out_valid_reg, out_valid_next;
    logic                        out_vv_reg, out_vv_next;
    logic [frl_pkg::FRAME_W-1:0] out_frame_reg, out_frame_next;

    // Memory ports
    logic                        ring_wr_en;
    logic [IDX_W-1:0]            ring_rd_addr;
    logic [frl_pkg::FRAME_W-1:0] ring_rd_data;
    logic                        stamp_wr_en;
    logic [IDX_W-1:0]            stamp_rd_addr;
    logic [frl_pkg::STAMP_W-1:0] stamp_rd_data;

    logic                        accept;
    logic                        in_range;
    logic                        issue;
    logic                        match;
    logic [IDX_W-1:0]            frame_idx;
    logic [IDX_W-1:0]            in_idx;

    frl_ring #(
        .DEPTH  (FRAME_COUNT),
        .ADDR_W (IDX_W)
    ) u_ring (
        .clk     (clk),
        .wr_en   (ring_wr_en),
        .wr_addr (tail_reg),
        .wr_data (frame_reg),
        .rd_addr (ring_rd_addr),
        .rd_data (ring_rd_data)
    );

    frl_stamp #(
        .DEPTH  (FRAME_COUNT),
        .ADDR_W (IDX_W)
    ) u_stamp (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (stamp_wr_en),
        .wr_addr (frame_idx),
        .wr_data (clock_next),
        .rd_addr (stamp_rd_addr),
        .rd_data (stamp_rd_data)
    );

    // Handshakes and output payload
    assign item_in.ready           = (state_reg == frl_pkg::ST_IDLE);
    assign accept                  = item_in.valid && item_in.ready;
    assign in_range                = ({28'd0, item_in.frame} < 32'(FRAME_COUNT));
    assign in_idx                  = IDX_W'(item_in.frame);
    assign frame_idx               = IDX_W'(frame_reg);
    assign result_out.valid        = out_valid_reg;
    assign result_out.victim_valid = out_vv_reg;
    assign result_out.victim_frame = out_frame_reg;

    // State and control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= frl_pkg::ST_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            clock_reg     <= '0;
            occ_reg       <= '0;
            idx_reg       <= '0;
            pos_reg       <= '0;
            pend_reg      <= 1'b0;
            hit_reg       <= 1'b0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            clock_reg     <= clock_next;
            occ_reg       <= occ_next;
            idx_reg       <= idx_next;
            pos_reg       <= pos_next;
            pend_reg      <= pend_next;
            hit_reg       <= hit_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        frame_reg     <= frame_next;
        pend_occ_reg  <= pend_occ_next;
        pend_idx_reg  <= pend_idx_next;
        best_reg      <= best_next;
        best_idx_reg  <= best_idx_next;
        res_vv_reg    <= res_vv_next;
        res_frame_reg <= res_frame_next;
        out_vv_reg    <= out_vv_next;
        out_frame_reg <= out_frame_next;
    end

    // Sequencer: next state and datapath control
    always_comb
    begin
        state_next     = state_reg;
        frame_next     = frame_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        count_next     = count_reg;
        clock_next     = clock_reg;
        occ_next       = occ_reg;
        idx_next       = idx_reg;
        pos_next       = pos_reg;
        pend_next      = pend_reg;
        pend_occ_next  = pend_occ_reg;
        pend_idx_next  = pend_idx_reg;
        hit_next       = hit_reg;
        found_next     = found_reg;
        best_next      = best_reg;
        best_idx_next  = best_idx_reg;
        res_vv_next    = res_vv_reg;
        res_frame_next = res_frame_reg;
        out_vv_next    = out_vv_reg;
        out_frame_next = out_frame_reg;
        ring_wr_en     = 1'b0;
        ring_rd_addr   = pos_reg;
        stamp_wr_en    = 1'b0;
        stamp_rd_addr  = idx_reg[IDX_W-1:0];
        issue          = 1'b0;
        match          = 1'b0;

        // Output register drains when taken
        out_valid_next = out_valid_reg && !result_out.ready;

        unique case (state_reg)
            frl_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    frame_next = item_in.frame;
                    idx_next   = '0;
                    pend_next  = 1'b0;
                    hit_next   = 1'b0;
                    found_next = 1'b0;
                    unique case (frl_pkg::kind_t'(item_in.kind))
                        frl_pkg::KIND_USE:
                        begin
                            if (in_range)
                            begin
                                pos_next   = head_reg;
                                state_next = frl_pkg::ST_USE_SCAN;
                            end
                        end
                        frl_pkg::KIND_FIFO:
                        begin
                            if (count_reg == '0)
                            begin
                                res_vv_next    = 1'b0;
                                res_frame_next = '0;
                                state_next     = frl_pkg::ST_EMIT;
                            end
                            else
                            begin
                                state_next = frl_pkg::ST_FIFO_RD;
                            end
                        end
                        frl_pkg::KIND_LRU:
                        begin
                            state_next = frl_pkg::ST_LRU_SCAN;
                        end
                        frl_pkg::KIND_OCC:
                        begin
                            if (in_range)
                            begin
                                occ_next[in_idx] = item_in.occupied_value;
                            end
                        end
                        default:
                        begin
                            state_next = frl_pkg::ST_IDLE;
                        end
                    endcase
                end
            end

            // Presence scan over the queued window, one entry a cycle
            frl_pkg::ST_USE_SCAN:
            begin
                match = pend_reg && (ring_rd_data == frame_reg);
                issue = !hit_reg && !match && (idx_reg < count_reg);
                if (match)
                begin
                    hit_next = 1'b1;
                end
                pend_next = issue;
                if (issue)
                begin
                    idx_next = idx_reg + 1'b1;
                    pos_next = (pos_reg == IDX_LAST) ? '0 : pos_reg + 1'b1;
                end
                if (!issue && (match || !pend_reg))
                begin
                    state_next = frl_pkg::ST_USE_UPD;
                end
            end

            // Enqueue if absent and room, stamp with the saturating clock
            frl_pkg::ST_USE_UPD:
            begin
                if (!hit_reg && (count_reg < CNT_FULL))
                begin
                    ring_wr_en = 1'b1;
                    tail_next  = (tail_reg == IDX_LAST) ? '0 : tail_reg + 1'b1;
                    count_next = count_reg + 1'b1;
                end
                if (clock_reg != '1)
                begin
                    clock_next = clock_reg + 1'b1;
                end
                stamp_wr_en = 1'b1;
                state_next  = frl_pkg::ST_IDLE;
            end

            // Pop the oldest queued frame
            frl_pkg::ST_FIFO_RD:
            begin
                ring_rd_addr = head_reg;
                state_next   = frl_pkg::ST_FIFO_WAIT;
            end

            frl_pkg::ST_FIFO_WAIT:
            begin
                res_vv_next    = 1'b1;
                res_frame_next = ring_rd_data;
                head_next      = (head_reg == IDX_LAST) ? '0 : head_reg + 1'b1;
                count_next     = count_reg - 1'b1;
                state_next     = frl_pkg::ST_EMIT;
            end

            // Minimum stamp over occupied frames, lowest index wins ties
            frl_pkg::ST_LRU_SCAN:
            begin
                issue = (idx_reg < CNT_FULL);
                if (pend_reg && pend_occ_reg
                    && (!found_reg || (stamp_rd_data < best_reg)))
                begin
                    found_next    = 1'b1;
                    best_next     = stamp_rd_data;
                    best_idx_next = pend_idx_reg;
                end
                pend_next     = issue;
                pend_occ_next = occ_reg[idx_reg[IDX_W-1:0]];
                pend_idx_next = idx_reg[IDX_W-1:0];
                if (issue)
                begin
                    idx_next = idx_reg + 1'b1;
                end
                if (!issue && !pend_reg)
                begin
                    res_vv_next    = found_reg;
                    res_frame_next = found_reg ? frl_pkg::FRAME_W'(best_idx_reg) : '0;
                    state_next     = frl_pkg::ST_EMIT;
                end
            end

            // Load the output register once it is free
            frl_pkg::ST_EMIT:
            begin
                if (!out_valid_reg || result_out.ready)
                begin
                    out_valid_next = 1'b1;
                    out_vv_next    = res_vv_reg;
                    out_frame_next = res_frame_reg;
                    state_next     = frl_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = frl_pkg::ST_IDLE;
            end
        endcase
    end

endmodule
